### design/tgro_pkg.sv
package tgro_pkg;

  // Field and register widths
  localparam int TILE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 15;
  localparam int IDX_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Tile coordinate width in queue entries, covers grids up to 1024 tiles a side
  localparam int CRD_W = 10;

  // Divider: 17-bit dividend, one quotient bit per cycle
  localparam int DIV_W     = 17;
  localparam int DIV_CNT_W = 5;

  // Command queue between front and back
  localparam int QDEPTH  = 4;
  localparam int Q_PTR_W = 2;

  // Empty tile id
  localparam logic signed [COORD_W-1:0] TILE_EMPTY = -16'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_W   = 3'd0,
    CFG_TILE_H   = 3'd1,
    CFG_MAP_COLS = 3'd2,
    CFG_MAP_ROWS = 3'd3,
    CFG_ORIGIN_X = 3'd4,
    CFG_ORIGIN_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SCAN,
    OP_RESULT
  } cmd_op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CHECK,
    F_DIV,
    F_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_RESULT
  } be_state_t;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          tile_col;
    logic [IDX_W-1:0]          tile_row;
    logic signed [COORD_W-1:0] tile_id;
    logic                      new_map;
    logic signed [COORD_W-1:0] ent_x;
    logic signed [COORD_W-1:0] ent_y;
    logic [SIZE_W-1:0]         ent_w;
    logic [SIZE_W-1:0]         ent_h;
  } in_item_t;

  typedef struct packed {
    logic in_bounds;
    logic hit;
  } out_item_t;

  // Queue entry; a write uses col_lo/row_lo as the tile address
  typedef struct packed {
    cmd_op_t          op;
    logic [CRD_W-1:0] col_lo;
    logic [CRD_W-1:0] col_hi;
    logic [CRD_W-1:0] row_lo;
    logic [CRD_W-1:0] row_hi;
    logic             full;
    logic             in_bounds;
  } cmd_t;

endpackage

### design/tgro_stream_if.sv
interface tgro_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/tile_grid_rect_overlap_unit.sv
// Channel   Dir  Payload                                        Handshake
// in_ch     in   kind, tile_col/row, tile_id, new_map,          valid/ready
//                ent_x/y, ent_w/h
// out_ch    out  in_bounds, hit (one item per query)            valid/ready
// cfg_*     in   cfg_idx, cfg_data                              cfg_we, no stall
//
// A write item is taken straight from idle. A query whose corner lies inside the extent
// passes through the front's offset, extent check, bit-serial divide and queue push;
// one outside the extent skips the divide. The back then reads the occupancy
// memory one tile a cycle, stopping at the first occupied tile. The back's single
// read port sets the scan length.
// After reset the back clears MAX_COLS*MAX_ROWS tiles (16384 by default), one a
// cycle, with in_ch.ready low; configuration writes are taken throughout.
// A four-entry command queue lets the front keep taking items while the back
// scans or waits on out_ch.ready.
module tile_grid_rect_overlap_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tgro_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tgro_pkg::CFG_DATA_W-1:0] cfg_data,
  tgro_stream_if.sink                   in_ch,
  tgro_stream_if.source                 out_ch
);

  logic           q_push, q_full, q_pop, q_empty, clearing;
  tgro_pkg::cmd_t q_data, q_head;

  tgro_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst_n, .in_ch, .cfg_we, .cfg_idx, .cfg_data, .clearing,
    .q_push, .q_data, .q_full
  );

  tgro_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  tgro_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst_n, .q_head, .q_empty, .q_pop, .clearing, .out_ch
  );

  // No item is taken while the grid is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted during clearing pass");

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue underflow");

  // The clearing pass ends once and never restarts
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");

endmodule

### design/tgro_div.sv
module tgro_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tgro_pkg::DIV_W-1:0]  dividend,
  input  logic [tgro_pkg::TILE_W-1:0] divisor,
  output logic                       busy,
  output logic [tgro_pkg::DIV_W-1:0]  quot
);

  logic [tgro_pkg::DIV_W-1:0]     q_r, q_nxt;
  logic [tgro_pkg::TILE_W-1:0]    rem_r, rem_nxt;
  logic [tgro_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic [tgro_pkg::TILE_W:0]      trial;
  logic [tgro_pkg::TILE_W:0]      diff;
  logic                           ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, q_r[tgro_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[tgro_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? diff[tgro_pkg::TILE_W-1:0] : trial[tgro_pkg::TILE_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tgro_pkg::DIV_CNT_W'(tgro_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

### design/tgro_front.sv
module tgro_front #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tgro_stream_if.sink                   in_ch,
  input  logic                          cfg_we,
  input  logic [tgro_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tgro_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          clearing,
  output logic                          q_push,
  output tgro_pkg::cmd_t                q_data,
  input  logic                          q_full
);

  localparam int DW = tgro_pkg::DIV_W;
  localparam int TW = tgro_pkg::TILE_W;

  tgro_pkg::fe_state_t state_r, state_nxt;

  // Configuration registers
  logic [TW-1:0]                    tile_w_r, tile_h_r, map_cols_r, map_rows_r;
  logic [tgro_pkg::COORD_W-1:0]     origin_x_r, origin_y_r;

  // Occupied extent
  logic [TW-1:0] ext_cols_r, ext_cols_nxt, ext_rows_r, ext_rows_nxt;

  // Query datapath
  logic [DW-1:0]               rx_r, rx_nxt, ry_r, ry_nxt;
  logic [tgro_pkg::SIZE_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic                        ib_r, ib_nxt;

  logic                        in_rdy, in_acc;
  logic                        wr_in_grid, wr_full;
  logic [TW-1:0]               col_p1, row_p1;
  logic [tgro_pkg::COORD_W-1:0] lim_x, lim_y;
  logic                        ib_x, ib_y;
  logic [DW-1:0]               xs, ys, dxr, dyr;
  logic                        div_start, div_busy, busy_xr, busy_yl, busy_yr;
  logic [DW-1:0]               qxl, qxr, qyl, qyr;
  logic [DW-1:0]               cols_v, rows_v, xr_c, yr_c;
  logic                        range_empty;

  // Accept only in idle, with the grid cleared and room for a write command
  assign in_rdy      = (state_r == tgro_pkg::F_IDLE) && !clearing && !q_full;
  assign in_ch.ready = in_rdy;
  assign in_acc      = in_ch.valid && in_rdy;

  // Write classification
  assign wr_in_grid = ({{(DW-tgro_pkg::IDX_W){1'b0}}, in_ch.data.tile_col} < DW'(MAX_COLS)) &&
                      ({{(DW-tgro_pkg::IDX_W){1'b0}}, in_ch.data.tile_row} < DW'(MAX_ROWS));
  assign wr_full    = (in_ch.data.tile_id != tgro_pkg::TILE_EMPTY);
  assign col_p1     = {1'b0, in_ch.data.tile_col} + 1'b1;
  assign row_p1     = {1'b0, in_ch.data.tile_row} + 1'b1;

  // Extent in pixels and corner check
  assign lim_x = ext_cols_r * tile_w_r;
  assign lim_y = ext_rows_r * tile_h_r;
  assign ib_x  = !rx_r[DW-1] && (rx_r[DW-2:0] < lim_x);
  assign ib_y  = !ry_r[DW-1] && (ry_r[DW-2:0] < lim_y);

  // Far edge: x+w-1, held at zero when it goes negative
  assign xs  = {1'b0, rx_r[DW-2:0]} + {2'b0, w_r};
  assign ys  = {1'b0, ry_r[DW-2:0]} + {2'b0, h_r};
  assign dxr = (xs == '0) ? '0 : xs - 1'b1;
  assign dyr = (ys == '0) ? '0 : ys - 1'b1;

  tgro_div u_div_xl (
    .clk, .rst_n, .start(div_start), .dividend({1'b0, rx_r[DW-2:0]}),
    .divisor(tile_w_r), .busy(div_busy), .quot(qxl)
  );
  tgro_div u_div_xr (
    .clk, .rst_n, .start(div_start), .dividend(dxr),
    .divisor(tile_w_r), .busy(busy_xr), .quot(qxr)
  );
  tgro_div u_div_yl (
    .clk, .rst_n, .start(div_start), .dividend({1'b0, ry_r[DW-2:0]}),
    .divisor(tile_h_r), .busy(busy_yl), .quot(qyl)
  );
  tgro_div u_div_yr (
    .clk, .rst_n, .start(div_start), .dividend(dyr),
    .divisor(tile_h_r), .busy(busy_yr), .quot(qyr)
  );

  // Clamp the far edge to the map size in use
  assign cols_v = ({{(DW-TW){1'b0}}, map_cols_r} > DW'(MAX_COLS)) ?
                  DW'(MAX_COLS) : {{(DW-TW){1'b0}}, map_cols_r};
  assign rows_v = ({{(DW-TW){1'b0}}, map_rows_r} > DW'(MAX_ROWS)) ?
                  DW'(MAX_ROWS) : {{(DW-TW){1'b0}}, map_rows_r};
  assign xr_c   = (qxr > cols_v - 1'b1) ? cols_v - 1'b1 : qxr;
  assign yr_c   = (qyr > rows_v - 1'b1) ? rows_v - 1'b1 : qyr;
  assign range_empty = (cols_v == '0) || (rows_v == '0) || (qxl > xr_c) || (qyl > yr_c);

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    ext_cols_nxt = ext_cols_r;
    ext_rows_nxt = ext_rows_r;
    rx_nxt       = rx_r;
    ry_nxt       = ry_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    ib_nxt       = ib_r;
    div_start    = 1'b0;
    q_push       = 1'b0;
    q_data       = '0;
    case (state_r)
      tgro_pkg::F_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.kind == tgro_pkg::KIND_WRITE) begin
            // Update extent now so later queries see it in order
            if (in_ch.data.new_map) begin
              ext_cols_nxt = '0;
              ext_rows_nxt = '0;
            end
            if (wr_in_grid && wr_full) begin
              if (col_p1 > (in_ch.data.new_map ? '0 : ext_cols_r)) ext_cols_nxt = col_p1;
              if (row_p1 > (in_ch.data.new_map ? '0 : ext_rows_r)) ext_rows_nxt = row_p1;
            end
            q_push        = wr_in_grid;
            q_data.op     = tgro_pkg::OP_WRITE;
            q_data.col_lo = tgro_pkg::CRD_W'(in_ch.data.tile_col);
            q_data.row_lo = tgro_pkg::CRD_W'(in_ch.data.tile_row);
            q_data.full   = wr_full;
          end else begin
            rx_nxt    = {in_ch.data.ent_x[15], in_ch.data.ent_x} - {origin_x_r[15], origin_x_r};
            ry_nxt    = {in_ch.data.ent_y[15], in_ch.data.ent_y} - {origin_y_r[15], origin_y_r};
            w_nxt     = in_ch.data.ent_w;
            h_nxt     = in_ch.data.ent_h;
            state_nxt = tgro_pkg::F_CHECK;
          end
        end
      end
      tgro_pkg::F_CHECK: begin
        ib_nxt = ib_x && ib_y;
        if (ib_x && ib_y) begin
          div_start = 1'b1;
          state_nxt = tgro_pkg::F_DIV;
        end else begin
          state_nxt = tgro_pkg::F_PUSH;
        end
      end
      tgro_pkg::F_DIV: begin
        if (!(div_busy || busy_xr || busy_yl || busy_yr)) state_nxt = tgro_pkg::F_PUSH;
      end
      tgro_pkg::F_PUSH: begin
        q_data.op        = (ib_r && !range_empty) ? tgro_pkg::OP_SCAN : tgro_pkg::OP_RESULT;
        q_data.col_lo    = tgro_pkg::CRD_W'(qxl);
        q_data.col_hi    = tgro_pkg::CRD_W'(xr_c);
        q_data.row_lo    = tgro_pkg::CRD_W'(qyl);
        q_data.row_hi    = tgro_pkg::CRD_W'(yr_c);
        q_data.in_bounds = ib_r;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = tgro_pkg::F_IDLE;
        end
      end
      default: state_nxt = tgro_pkg::F_IDLE;
    endcase
  end

  // State, configuration and extent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tgro_pkg::F_IDLE;
      ext_cols_r <= '0;
      ext_rows_r <= '0;
      tile_w_r   <= 8'd16;
      tile_h_r   <= 8'd16;
      map_cols_r <= 8'd128;
      map_rows_r <= 8'd128;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ext_cols_r <= ext_cols_nxt;
      ext_rows_r <= ext_rows_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          tgro_pkg::CFG_TILE_W:   tile_w_r   <= cfg_data[TW-1:0];
          tgro_pkg::CFG_TILE_H:   tile_h_r   <= cfg_data[TW-1:0];
          tgro_pkg::CFG_MAP_COLS: map_cols_r <= cfg_data[TW-1:0];
          tgro_pkg::CFG_MAP_ROWS: map_rows_r <= cfg_data[TW-1:0];
          tgro_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
          tgro_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Query payload
  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    w_r  <= w_nxt;
    h_r  <= h_nxt;
    ib_r <= ib_nxt;
  end

endmodule

### design/tgro_fifo.sv
module tgro_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tgro_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tgro_pkg::cmd_t head
);

  tgro_pkg::cmd_t                ent_r [tgro_pkg::QDEPTH];
  logic [tgro_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [tgro_pkg::Q_PTR_W:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full    = (cnt_r == (tgro_pkg::Q_PTR_W + 1)'(tgro_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_data;
  end

endmodule

### design/tgro_back.sv
module tgro_back #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tgro_pkg::cmd_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           clearing,
  tgro_stream_if.source  out_ch
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = tgro_pkg::CRD_W;

  tgro_pkg::be_state_t state_r, state_nxt;

  logic          occ_r [0:DEPTH-1];
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0] col_hi_r, col_hi_nxt, row_lo_r, row_lo_nxt, row_hi_r, row_hi_nxt;
  logic          issued_r, issued_nxt;
  logic          rd_vld_r, rd_last_r, rd_bit_r;
  logic          res_ib_r, res_ib_nxt, res_hit_r, res_hit_nxt;
  logic          out_vld_r, out_vld_nxt, out_ib_r, out_ib_nxt, out_hit_r, out_hit_nxt;

  logic          we, wbit, rd_issue, last_cell;
  logic [AW-1:0] waddr, raddr;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  assign clearing  = (state_r == tgro_pkg::B_CLEAR);
  assign raddr     = cell_addr(row_r, col_r);
  assign last_cell = (col_r == col_hi_r) && (row_r == row_hi_r);

  assign out_ch.valid          = out_vld_r;
  assign out_ch.data.in_bounds = out_ib_r;
  assign out_ch.data.hit       = out_hit_r;

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    col_hi_nxt   = col_hi_r;
    row_lo_nxt   = row_lo_r;
    row_hi_nxt   = row_hi_r;
    issued_nxt   = issued_r;
    res_ib_nxt   = res_ib_r;
    res_hit_nxt  = res_hit_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ib_nxt   = out_ib_r;
    out_hit_nxt  = out_hit_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = clr_addr_r;
    wbit         = 1'b0;
    rd_issue     = 1'b0;
    case (state_r)
      tgro_pkg::B_CLEAR: begin
        // Sweep the grid to empty, one tile a cycle
        we           = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = tgro_pkg::B_IDLE;
      end
      tgro_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_head.op)
            tgro_pkg::OP_WRITE: begin
              we    = 1'b1;
              waddr = cell_addr(q_head.row_lo, q_head.col_lo);
              wbit  = q_head.full;
            end
            tgro_pkg::OP_SCAN: begin
              col_nxt    = q_head.col_lo;
              col_hi_nxt = q_head.col_hi;
              row_nxt    = q_head.row_lo;
              row_lo_nxt = q_head.row_lo;
              row_hi_nxt = q_head.row_hi;
              issued_nxt = 1'b0;
              state_nxt  = tgro_pkg::B_SCAN;
            end
            tgro_pkg::OP_RESULT: begin
              res_ib_nxt  = q_head.in_bounds;
              res_hit_nxt = 1'b0;
              state_nxt   = tgro_pkg::B_RESULT;
            end
            default: ;
          endcase
        end
      end
      tgro_pkg::B_SCAN: begin
        // Issue one read a cycle, rows inner, columns outer
        if (!issued_r) begin
          rd_issue = 1'b1;
          if (last_cell) begin
            issued_nxt = 1'b1;
          end else if (row_r == row_hi_r) begin
            row_nxt = row_lo_r;
            col_nxt = col_r + 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
        // Stop at the first occupied tile or after the last one
        if (rd_vld_r && (rd_bit_r || rd_last_r)) begin
          res_ib_nxt  = 1'b1;
          res_hit_nxt = rd_bit_r;
          state_nxt   = tgro_pkg::B_RESULT;
        end
      end
      tgro_pkg::B_RESULT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_ib_nxt  = res_ib_r;
          out_hit_nxt = res_hit_r;
          state_nxt   = tgro_pkg::B_IDLE;
        end
      end
      default: state_nxt = tgro_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tgro_pkg::B_CLEAR;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_vld_r   <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    col_hi_r  <= col_hi_nxt;
    row_lo_r  <= row_lo_nxt;
    row_hi_r  <= row_hi_nxt;
    issued_r  <= issued_nxt;
    res_ib_r  <= res_ib_nxt;
    res_hit_r <= res_hit_nxt;
    out_ib_r  <= out_ib_nxt;
    out_hit_r <= out_hit_nxt;
    rd_last_r <= rd_issue && last_cell;
  end

  // Occupancy memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) occ_r[waddr] <= wbit;
    if (rd_issue) rd_bit_r <= occ_r[raddr];
  end

endmodule

### bench/tile_grid_rect_overlap_unit_tb.sv
`timescale 1ns / 100ps

module tile_grid_rect_overlap_unit_tb;

  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 128;
  localparam int GRID_AW   = $clog2(GRID_COLS*GRID_ROWS);

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [tgro_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tgro_pkg::CFG_DATA_W-1:0] cfg_data;

  tgro_stream_if #(.T(tgro_pkg::in_item_t)) in_if ();
  tgro_stream_if #(.T(tgro_pkg::out_item_t)) out_if ();

  tile_grid_rect_overlap_unit #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always #10 clk = ~clk;

  // Mirror of the grid, the occupied extent and the registers
  bit grid_occ [GRID_COLS*GRID_ROWS];
  int ext_cols, ext_rows;
  int cur_tw, cur_th, cur_cols, cur_rows, cur_ox, cur_oy;

  tgro_pkg::in_item_t tile_items [$];
  tgro_pkg::out_item_t overlap_due [$];
  int items_queued, items_taken, results_seen, err_cnt;

  tgro_pkg::in_item_t drv_item;
  int drv_wait;
  bit drv_calm;
  int rdy_hold;
  bit snk_calm;
  tgro_pkg::out_item_t want;

  // Random idle length: mostly none or short, a few long
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Last covered tile on one axis, truncating toward zero
  function automatic int last_cover(int pos, int len, int size);
    int v;
    v = pos + len - 1;
    return (v < 0) ? 0 : v / size;
  endfunction

  function automatic tgro_pkg::out_item_t query_overlap(tgro_pkg::in_item_t it);
    tgro_pkg::out_item_t r;
    int rx, ry, lim_x, lim_y, c0, c1, r0, r1, ncols, nrows, i, j;
    r = '0;
    rx = int'(it.ent_x) - cur_ox;
    ry = int'(it.ent_y) - cur_oy;
    lim_x = ext_cols * cur_tw;
    lim_y = ext_rows * cur_th;
    if (rx < 0 || rx >= lim_x || ry < 0 || ry >= lim_y || cur_tw == 0 || cur_th == 0)
      return r;
    r.in_bounds = 1'b1;
    ncols = (cur_cols > GRID_COLS) ? GRID_COLS : cur_cols;
    nrows = (cur_rows > GRID_ROWS) ? GRID_ROWS : cur_rows;
    c0 = rx / cur_tw;
    r0 = ry / cur_th;
    c1 = last_cover(rx, int'(it.ent_w), cur_tw);
    r1 = last_cover(ry, int'(it.ent_h), cur_th);
    if (c1 > ncols - 1) c1 = ncols - 1;
    if (r1 > nrows - 1) r1 = nrows - 1;
    for (i = c0; i <= c1; i++)
      for (j = r0; j <= r1; j++)
        if (grid_occ[GRID_AW'(j*GRID_COLS + i)]) r.hit = 1'b1;
    return r;
  endfunction

  // Advance the grid mirror by one accepted item, queue a result for a query
  task automatic step_tile_grid(tgro_pkg::in_item_t it);
    bit filled;
    if (it.kind == tgro_pkg::KIND_QUERY) begin
      overlap_due.push_back(query_overlap(it));
    end else begin
      filled = (it.tile_id != tgro_pkg::TILE_EMPTY);
      if (it.new_map) begin
        ext_cols = 0;
        ext_rows = 0;
      end
      grid_occ[GRID_AW'(int'(it.tile_row)*GRID_COLS + int'(it.tile_col))] = filled;
      if (filled) begin
        if (int'(it.tile_col) + 1 > ext_cols) ext_cols = int'(it.tile_col) + 1;
        if (int'(it.tile_row) + 1 > ext_rows) ext_rows = int'(it.tile_row) + 1;
      end
    end
  endtask

  function automatic tgro_pkg::in_item_t rnd_raw();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(tgro_pkg::in_item_t)-1:0];
  endfunction

  function automatic tgro_pkg::in_item_t mk_write(int col, int row, int id, bit nm);
    tgro_pkg::in_item_t it;
    it = rnd_raw();
    it.kind = tgro_pkg::KIND_WRITE;
    it.tile_col = col[tgro_pkg::IDX_W-1:0];
    it.tile_row = row[tgro_pkg::IDX_W-1:0];
    it.tile_id = id[tgro_pkg::COORD_W-1:0];
    it.new_map = nm;
    return it;
  endfunction

  function automatic tgro_pkg::in_item_t mk_query(int x, int y, int w, int h);
    tgro_pkg::in_item_t it;
    it = rnd_raw();
    it.kind = tgro_pkg::KIND_QUERY;
    it.ent_x = x[tgro_pkg::COORD_W-1:0];
    it.ent_y = y[tgro_pkg::COORD_W-1:0];
    it.ent_w = w[tgro_pkg::SIZE_W-1:0];
    it.ent_h = h[tgro_pkg::SIZE_W-1:0];
    return it;
  endfunction

  // Write mostly into a hot corner of the grid so that queries find tiles
  function automatic tgro_pkg::in_item_t rnd_write(int span_c, int span_r);
    tgro_pkg::in_item_t it;
    it = rnd_raw();
    it.kind = tgro_pkg::KIND_WRITE;
    if ($urandom_range(0, 99) < 70) begin
      it.tile_col = tgro_pkg::IDX_W'($urandom_range(0, span_c - 1));
      it.tile_row = tgro_pkg::IDX_W'($urandom_range(0, span_r - 1));
    end
    if ($urandom_range(0, 99) < 35) it.tile_id = tgro_pkg::TILE_EMPTY;
    else it.tile_id = tgro_pkg::COORD_W'($urandom_range(0, 32767));
    it.new_map = ($urandom_range(0, 99) < 3);
    return it;
  endfunction

  // Place one corner relative to the origin: hot area, edges of the extent, or anywhere
  function automatic logic [tgro_pkg::COORD_W-1:0] rnd_corner(int org, int span, int tsz,
                                                              int ext);
    int roll, rel, v;
    roll = $urandom_range(0, 99);
    if (roll < 75) rel = $urandom_range(0, span*tsz - 1);
    else if (roll < 82) rel = -int'($urandom_range(1, tsz));
    else if (roll < 90) rel = ext*tsz - 1 + int'($urandom_range(0, 1));
    else return tgro_pkg::COORD_W'($urandom);
    v = org + rel;
    return v[tgro_pkg::COORD_W-1:0];
  endfunction

  // Keep one side of a rectangle small so a scan stays short
  function automatic tgro_pkg::in_item_t rnd_query(int span_c, int span_r);
    tgro_pkg::in_item_t it;
    int tw, th, roll;
    it = rnd_raw();
    it.kind = tgro_pkg::KIND_QUERY;
    tw = (cur_tw == 0) ? 1 : cur_tw;
    th = (cur_th == 0) ? 1 : cur_th;
    it.ent_x = rnd_corner(cur_ox, span_c, tw, ext_cols);
    it.ent_y = rnd_corner(cur_oy, span_r, th, ext_rows);
    it.ent_w = tgro_pkg::SIZE_W'($urandom_range(0, 3*tw));
    it.ent_h = tgro_pkg::SIZE_W'($urandom_range(0, 3*th));
    roll = $urandom_range(0, 99);
    if (roll < 6) it.ent_w = tgro_pkg::SIZE_W'($urandom_range(0, 32767));
    else if (roll < 12) it.ent_h = tgro_pkg::SIZE_W'($urandom_range(0, 32767));
    return it;
  endfunction

  task automatic queue_item(tgro_pkg::in_item_t it);
    tile_items.push_back(it);
    items_queued++;
  endtask

  // Hold until every item is taken and every result is back, then let writes drain
  task automatic settle();
    while (items_taken != items_queued || overlap_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic put_reg(tgro_pkg::cfg_reg_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[tgro_pkg::CFG_DATA_W-1:0];
    case (idx)
      tgro_pkg::CFG_TILE_W:   cur_tw = value & 'hFF;
      tgro_pkg::CFG_TILE_H:   cur_th = value & 'hFF;
      tgro_pkg::CFG_MAP_COLS: cur_cols = value & 'hFF;
      tgro_pkg::CFG_MAP_ROWS: cur_rows = value & 'hFF;
      tgro_pkg::CFG_ORIGIN_X: cur_ox = int'($signed(value[15:0]));
      tgro_pkg::CFG_ORIGIN_Y: cur_oy = int'($signed(value[15:0]));
      default: ;
    endcase
  endtask

  task automatic load_setup(int tw, int th, int cols, int rows, int ox, int oy);
    put_reg(tgro_pkg::CFG_TILE_W, tw);
    put_reg(tgro_pkg::CFG_TILE_H, th);
    put_reg(tgro_pkg::CFG_MAP_COLS, cols);
    put_reg(tgro_pkg::CFG_MAP_ROWS, rows);
    put_reg(tgro_pkg::CFG_ORIGIN_X, ox);
    put_reg(tgro_pkg::CFG_ORIGIN_Y, oy);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random phase: a block of writes to build up the map, then a mix
  task automatic run_mix(int n);
    int span_c, span_r, k;
    span_c = (cur_cols > 12) ? 12 : ((cur_cols < 1) ? 1 : cur_cols);
    span_r = (cur_rows > 12) ? 12 : ((cur_rows < 1) ? 1 : cur_rows);
    for (k = 0; k < n; k++) begin
      if (k < n/5 || $urandom_range(0, 99) < 40) queue_item(rnd_write(span_c, span_r));
      else queue_item(rnd_query(span_c, span_r));
    end
    settle();
  endtask

  // Input driver: present queued items with random gaps, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      drv_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        step_tile_grid(drv_item);
        items_taken++;
        if (items_taken % 64 == 0) drv_calm = ($urandom_range(0, 2) == 0);
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the item until taken
      end else if (drv_wait > 0) begin
        drv_wait--;
        in_if.valid <= 1'b0;
      end else if (tile_items.size() != 0) begin
        drv_item = tile_items.pop_front();
        in_if.data <= drv_item;
        in_if.valid <= 1'b1;
        drv_wait = drv_calm ? 0 : pick_idle();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor: check against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rdy_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (overlap_due.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: in_bounds %0b hit %0b",
                   $time, out_if.data.in_bounds, out_if.data.hit);
        end else begin
          want = overlap_due.pop_front();
          if (out_if.data.in_bounds !== want.in_bounds) begin
            err_cnt++;
            $display("%0t: in_bounds mismatch: expected %0b actual %0b",
                     $time, want.in_bounds, out_if.data.in_bounds);
          end
          if (out_if.data.hit !== want.hit) begin
            err_cnt++;
            $display("%0t: hit mismatch: expected %0b actual %0b",
                     $time, want.hit, out_if.data.hit);
          end
        end
        if (results_seen % 64 == 0) snk_calm = ($urandom_range(0, 2) == 0);
        // Long hold-off so the command queue fills and the input stalls
        if (results_seen == 120 || results_seen == 420) rdy_hold = 500;
      end
      if (rdy_hold > 0) begin
        rdy_hold--;
        out_if.ready <= 1'b0;
      end else begin
        rdy_hold = snk_calm ? 0 : pick_idle();
        out_if.ready <= (rdy_hold == 0);
      end
    end
  end

  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tgro_pkg::CFG_TILE_W;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    foreach (grid_occ[k]) grid_occ[k] = 1'b0;
    ext_cols = 0;
    ext_rows = 0;
    cur_tw = 16;
    cur_th = 16;
    cur_cols = 128;
    cur_rows = 128;
    cur_ox = 0;
    cur_oy = 0;
    items_queued = 0;
    items_taken = 0;
    results_seen = 0;
    err_cnt = 0;
    drv_calm = 1'b0;
    snk_calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, empty writes, new map, reversed and clamped ranges
    load_setup(16, 16, 128, 128, 0, 0);
    queue_item(mk_write(0, 0, 0, 1'b1));
    queue_item(mk_write(127, 127, 32767, 1'b0));
    queue_item(mk_write(5, 3, 1234, 1'b0));
    queue_item(mk_write(5, 3, -1, 1'b0));
    queue_item(mk_query(0, 0, 0, 0));
    queue_item(mk_query(-32768, -32768, 32767, 32767));
    queue_item(mk_query(32767, 32767, 0, 0));
    queue_item(mk_query(2047, 2047, 32767, 32767));
    queue_item(mk_query(80, 48, 1, 1));
    queue_item(mk_query(16, 16, 0, 0));
    queue_item(mk_query(16, 16, 32767, 32767));
    queue_item(mk_write(2, 2, -1, 1'b1));
    queue_item(mk_query(0, 0, 4, 4));
    queue_item(mk_write(2, 2, 5, 1'b0));
    queue_item(mk_query(0, 0, 47, 47));
    queue_item(mk_query(48, 0, 1, 1));
    settle();

    // Zero tile width: extent has no pixels
    load_setup(0, 16, 128, 128, 0, 0);
    queue_item(mk_write(1, 1, 7, 1'b0));
    queue_item(mk_query(0, 0, 5, 5));
    settle();

    // Zero map columns: nothing covered
    load_setup(16, 16, 0, 128, 0, 0);
    queue_item(mk_query(0, 0, 40, 40));
    settle();

    // Map size above the grid acts as the grid size
    load_setup(16, 16, 255, 200, 0, 0);
    queue_item(mk_write(127, 127, 9, 1'b0));
    queue_item(mk_query(2040, 2040, 32767, 32767));
    settle();

    // Origin at both extremes
    load_setup(2, 2, 128, 128, 32767, 32767);
    queue_item(mk_query(32767, 32767, 3, 3));
    settle();
    load_setup(2, 2, 128, 128, -32768, -32768);
    queue_item(mk_query(-32768, -32768, 0, 0));
    settle();

    // Random phases over a range of settings
    load_setup(16, 16, 128, 128, 0, 0);
    run_mix(220);
    load_setup(1, 1, 128, 128, -32768, -32768);
    run_mix(180);
    load_setup(255, 255, 1, 1, 0, 0);
    run_mix(140);
    load_setup(7, 13, 40, 90, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000);
    run_mix(220);
    load_setup(255, 1, 200, 255, 100, -100);
    run_mix(150);
    load_setup(5, 0, 64, 64, 0, 0);
    run_mix(40);
    load_setup(9, 6, 0, 64, 0, 0);
    run_mix(40);
    load_setup($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 128),
               $urandom_range(1, 128), $urandom_range(0, 8000) - 4000,
               $urandom_range(0, 8000) - 4000);
    run_mix(150);
    load_setup(3, 4, 128, 128, 32767, 32767);
    run_mix(40);

    if (err_cnt == 0 && overlap_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
